[src/c_comment_and_splice_stripper_macros.svh]
// Assertion macros shared by the comment stripper RTL.
`ifndef C_COMMENT_AND_SPLICE_STRIPPER_MACROS_SVH
`define C_COMMENT_AND_SPLICE_STRIPPER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CCSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ccss_pkg.sv]
// Types and constants shared by the comment stripper modules.
package ccss_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 20;
  localparam int CAP_W   = 21;

  localparam logic [CAP_W-1:0] CAP_LIMIT = 21'h10_0000;
  localparam logic [CAP_W-1:0] CAP_RESET = 21'h01_0000;

  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_SLASH  = 3'd1;
  localparam logic [2:0] MODE_BSLASH = 3'd2;
  localparam logic [2:0] MODE_LINE   = 3'd3;
  localparam logic [2:0] MODE_BLOCK  = 3'd4;
  localparam logic [2:0] MODE_BSTAR  = 3'd5;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               end_of_text;
    logic [COUNT_W-1:0] emitted_count;
    logic               overflow;
  } ccss_result_t;

  typedef struct packed {
    logic [1:0]   n;
    ccss_result_t r0;
    ccss_result_t r1;
  } ccss_push_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } ccss_status_t;

endpackage

[src/ccss_in_if.sv]
// Source byte channel: valid/ready handshake with byte and last flag.
interface ccss_in_if import ccss_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[src/ccss_out_if.sv]
// Result channel: valid/ready handshake with emitted byte and status.
interface ccss_out_if import ccss_pkg::*;;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               byte_valid;
  logic               end_of_text;
  logic [COUNT_W-1:0] emitted_count;
  logic               overflow;

  modport source (output valid, output out_byte, output byte_valid, output end_of_text,
                  output emitted_count, output overflow, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input end_of_text,
                  input emitted_count, input overflow, output ready);
endinterface

[src/ccss_scan.sv]
// Scanner: mode, byte count and overflow state, and the results of one byte.
module ccss_scan import ccss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               in_last,
  input  logic [CAP_W-1:0]   capacity,
  output ccss_push_t         push,
  output ccss_status_t       status
);

  logic [2:0]         mode_r, mode_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;

  logic [2:0]        fn_mode;
  logic              fn_v;
  logic [2:0]        nm;
  logic              a_v, b_v;
  logic [BYTE_W-1:0] a_b, b_b;

  logic [CAP_W-1:0]   lim, cnt_p1, cnt_p2;
  logic               fit1, fit2, e_a, e_b, ovf_a, ovf_b, ovf_f;
  logic [COUNT_W-1:0] cnt_b;
  ccss_result_t       res_a, res_b, res_bare;

  // Plain-text handling of the current byte
  always_comb begin
    fn_v    = 1'b0;
    fn_mode = MODE_NORMAL;
    if (in_byte == CH_SLASH) begin
      fn_mode = MODE_SLASH;
    end else if (in_byte == CH_BSLASH) begin
      fn_mode = MODE_BSLASH;
    end else begin
      fn_v = 1'b1;
    end
  end

  always_comb begin
    a_v = 1'b0;
    a_b = CH_SLASH;
    b_v = 1'b0;
    b_b = in_byte;
    nm  = fn_mode;
    unique case (mode_r)
      MODE_SLASH: begin
        if (in_byte == CH_SLASH) begin
          nm = MODE_LINE;
        end else if (in_byte == CH_STAR) begin
          nm = MODE_BLOCK;
        end else begin
          a_v = 1'b1;
          b_v = fn_v;
        end
      end
      MODE_BSLASH: begin
        a_b = CH_BSLASH;
        if (in_byte == CH_NL) begin
          nm = MODE_NORMAL;
        end else begin
          a_v = 1'b1;
          b_v = fn_v;
        end
      end
      MODE_LINE: begin
        if (in_byte == CH_NL) begin
          nm  = MODE_NORMAL;
          b_v = 1'b1;
        end else begin
          nm = MODE_LINE;
        end
      end
      MODE_BLOCK: begin
        nm = (in_byte == CH_STAR) ? MODE_BSTAR : MODE_BLOCK;
      end
      MODE_BSTAR: begin
        if (in_byte == CH_SLASH) begin
          nm = MODE_NORMAL;
        end else if (in_byte == CH_STAR) begin
          nm = MODE_BSTAR;
        end else begin
          nm = MODE_BLOCK;
        end
      end
      default: begin
        b_v = fn_v;
      end
    endcase
    // release a held slash or backslash at the end of the text
    if (in_last && nm == MODE_SLASH) begin
      b_v = 1'b1;
      b_b = CH_SLASH;
    end else if (in_last && nm == MODE_BSLASH) begin
      b_v = 1'b1;
      b_b = CH_BSLASH;
    end
  end

  // Capacity check for up to two emissions
  always_comb begin
    lim    = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
    cnt_p1 = {1'b0, cnt_r} + 21'd1;
    cnt_p2 = {1'b0, cnt_r} + 21'd2;
    fit1   = cnt_p1 < lim;
    fit2   = cnt_p2 < lim;
    e_a    = a_v && !ovf_r && fit1;
    ovf_a  = ovf_r || (a_v && !fit1);
    e_b    = b_v && !ovf_a && (e_a ? fit2 : fit1);
    ovf_b  = ovf_a || (b_v && !(e_a ? fit2 : fit1));
    cnt_b  = cnt_r + COUNT_W'(e_a) + COUNT_W'(e_b);
    ovf_f  = ovf_b || (in_last && ({1'b0, cnt_b} >= capacity));
  end

  always_comb begin
    res_a         = '{out_byte: a_b, byte_valid: 1'b1, end_of_text: 1'b0,
                      emitted_count: cnt_p1[COUNT_W-1:0], overflow: 1'b0};
    res_b         = '{out_byte: b_b, byte_valid: 1'b1, end_of_text: 1'b0,
                      emitted_count: e_a ? cnt_p2[COUNT_W-1:0] : cnt_p1[COUNT_W-1:0],
                      overflow: 1'b0};
    res_bare      = '{out_byte: '0, byte_valid: 1'b0, end_of_text: 1'b0,
                      emitted_count: cnt_b, overflow: 1'b0};
    push.r1 = res_b;
    push.r0 = e_a ? res_a : (e_b ? res_b : res_bare);
    if (e_a && e_b) begin
      push.n = 2'd2;
    end else if (e_a || e_b || in_last) begin
      push.n = 2'd1;
    end else begin
      push.n = 2'd0;
    end
    // mark the final result of the text with the closing overflow status
    if (in_last) begin
      if (e_a && e_b) begin
        push.r1.end_of_text = 1'b1;
        push.r1.overflow    = ovf_f;
      end else begin
        push.r0.end_of_text = 1'b1;
        push.r0.overflow    = ovf_f;
      end
    end
    if (!acc) begin
      push.n = 2'd0;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    if (acc) begin
      if (in_last) begin
        mode_nxt = MODE_NORMAL;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
      end else begin
        mode_nxt = nm;
        cnt_nxt  = cnt_b;
        ovf_nxt  = ovf_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign status = '{mode: mode_r, count: cnt_r, ovf: ovf_r};

endmodule

[src/ccss_outq.sv]
// Three-entry result queue: takes up to two results a cycle, delivers one.
module ccss_outq import ccss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ccss_push_t       push,
  output logic [1:0]       level,
  ccss_out_if.source       out_ch
);

  ccss_result_t q_r   [3];
  ccss_result_t q_nxt [3];
  logic [1:0]   level_r, level_nxt, base;
  logic         pop;

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    base      = level_r - {1'b0, pop};
    level_nxt = base + push.n;
    for (int i = 0; i < 3; i++) begin
      if (pop && i < 2) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push.n != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = push.r0;
      end
      if (push.n == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = push.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign level                = level_r;
  assign out_ch.valid         = level_r != 2'd0;
  assign out_ch.out_byte      = q_r[0].out_byte;
  assign out_ch.byte_valid    = q_r[0].byte_valid;
  assign out_ch.end_of_text   = q_r[0].end_of_text;
  assign out_ch.emitted_count = q_r[0].emitted_count;
  assign out_ch.overflow      = q_r[0].overflow;

endmodule

[src/c_comment_and_splice_stripper.sv]
// Top level: strips C comments and line splices from a byte stream.
// Results of a byte are registered in the result queue when it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and
// the sink takes each result; a byte yielding two results holds off input.
// Reset (rst_n low, synchronous): scanner back to plain text, count and
// overflow cleared, result queue emptied, capacity register to 65536.
`include "c_comment_and_splice_stripper_macros.svh"

module c_comment_and_splice_stripper import ccss_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ccss_in_if.sink      in_ch,
  ccss_out_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             cfg_wr;
  logic             in_acc;
  logic [1:0]       level;
  ccss_push_t       push;
  ccss_status_t     scan_st;
  logic             end_acc;
  logic             scan_idle;
  logic             out_bare;
  logic             out_mid;

  // Configuration port: zero wait states, capacity at word zero
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // read back the capacity; the unused word reads as zero
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_r} : 32'h0;

  // Accept a byte whenever the queue has room for two results; this depends
  // only on the registered fill level, so the two sides stay decoupled.
  assign in_ch.ready = level <= 2'd1;
  assign in_acc      = in_ch.valid && in_ch.ready;

  ccss_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .in_byte  (in_ch.in_byte),
    .in_last  (in_ch.in_last),
    .capacity (cap_r),
    .push     (push),
    .status   (scan_st)
  );

  // Hold results until the sink takes them
  ccss_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .level  (level),
    .out_ch (out_ch)
  );

  // Terms watched by the checks below
  assign end_acc   = in_acc && in_ch.in_last;
  assign scan_idle = scan_st.mode == MODE_NORMAL && scan_st.count == '0 && !scan_st.ovf;
  assign out_bare  = out_ch.valid && !out_ch.byte_valid;
  assign out_mid   = out_ch.valid && !out_ch.end_of_text;

  // A bare end marker only ever closes a text
  `CCSS_ASSERT_SAME(a_bare_is_end, out_bare, out_ch.end_of_text, "bare marker mid text")
  // Overflow is reported on the closing transaction alone
  `CCSS_ASSERT_SAME(a_ovf_at_end, out_mid, !out_ch.overflow && out_ch.byte_valid, "early overflow")
  // The last byte rearms the scanner for a fresh text
  `CCSS_ASSERT_NEXT(a_end_rearms, end_acc, scan_idle, "scanner not rearmed after last byte")

endmodule
